[rtl/aalr_pkg.sv]
// Package for the anti-aliased line rasteriser: field widths, payload structs,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
package aalr_pkg;

   // Default generics
   localparam int COORD_BITS_DEF = 6;
   localparam int FRAC_BITS_DEF  = 16;

   // Fixed field widths of the channels
   localparam int IN_COORD_W  = 6;
   localparam int PIX_W       = 7;
   localparam int WEIGHT_W    = 9;
   localparam int COLOR_W     = 24;
   localparam int CSR_W       = 7;
   localparam int CSR_INDEX_W = 1;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_BITMAP_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BITMAP_HEIGHT = 1'b1;

   localparam logic [CSR_W-1:0]    BITMAP_RESET = 7'd64;
   localparam logic [WEIGHT_W-1:0] WEIGHT_FULL  = 9'd256;
   localparam logic [WEIGHT_W-1:0] WEIGHT_HALF  = 9'd128;
   localparam logic [WEIGHT_W-1:0] WEIGHT_NONE  = 9'd0;

   typedef struct packed {
      logic [IN_COORD_W-1:0] x_start;
      logic [IN_COORD_W-1:0] y_start;
      logic [IN_COORD_W-1:0] x_finish;
      logic [IN_COORD_W-1:0] y_finish;
      logic [COLOR_W-1:0]    line_color;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0]    near_x;
      logic [PIX_W-1:0]    near_y;
      logic [WEIGHT_W-1:0] near_weight;
      logic                near_inside;
      logic [PIX_W-1:0]    far_x;
      logic [PIX_W-1:0]    far_y;
      logic [WEIGHT_W-1:0] far_weight;
      logic                far_inside;
      logic [COLOR_W-1:0]  pixel_color;
      logic                last_column;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ZERO,
      ST_DIVIDE,
      ST_FIRST,
      ST_SECOND,
      ST_BODY
   } state_type;

   // Which result the datapath builds for the output register
   typedef enum logic [1:0] {
      SEL_ZERO,
      SEL_FIRST,
      SEL_SECOND,
      SEL_BODY
   } out_sel_type;

   typedef struct packed {
      logic        load;
      logic        div_step;
      logic        start_body;
      logic        body_step;
      logic        out_load;
      out_sel_type out_sel;
   } cmd_type;

   typedef struct packed {
      logic zero_len;
      logic div_last;
      logic unit_dx;
      logic body_last;
      logic out_free;
   } status_type;

endpackage

[rtl/aalr_ctrl.sv]
// Controller of the line rasteriser: sequences load, slope division and result issue.
// Depends on aalr_pkg.
module aalr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  aalr_pkg::status_type status,
   output aalr_pkg::cmd_type    cmd
);

   aalr_pkg::state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= aalr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in       = state_ff;
      cmd.load       = 1'b0;
      cmd.div_step   = 1'b0;
      cmd.start_body = 1'b0;
      cmd.body_step  = 1'b0;
      cmd.out_load   = 1'b0;
      cmd.out_sel    = aalr_pkg::SEL_BODY;
      req_stall      = (state_ff != aalr_pkg::ST_IDLE);
      unique case (state_ff)
         aalr_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = status.zero_len ? aalr_pkg::ST_ZERO : aalr_pkg::ST_DIVIDE;
            end
         end
         aalr_pkg::ST_ZERO: begin
            cmd.out_sel = aalr_pkg::SEL_ZERO;
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = aalr_pkg::ST_IDLE;
            end
         end
         aalr_pkg::ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = aalr_pkg::ST_FIRST;
            end
         end
         aalr_pkg::ST_FIRST: begin
            cmd.out_sel = aalr_pkg::SEL_FIRST;
            if (status.out_free) begin
               cmd.out_load   = 1'b1;
               cmd.start_body = 1'b1;
               state_in       = aalr_pkg::ST_SECOND;
            end
         end
         aalr_pkg::ST_SECOND: begin
            cmd.out_sel = aalr_pkg::SEL_SECOND;
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = status.unit_dx ? aalr_pkg::ST_IDLE : aalr_pkg::ST_BODY;
            end
         end
         aalr_pkg::ST_BODY: begin
            cmd.out_sel = aalr_pkg::SEL_BODY;
            if (status.out_free) begin
               cmd.out_load  = 1'b1;
               cmd.body_step = 1'b1;
               if (status.body_last) begin
                  state_in = aalr_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = aalr_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

[rtl/aalr_datapath.sv]
// Datapath of the line rasteriser: endpoint ordering, restoring slope divider,
// minor-axis accumulator, clipping registers and the result output register.
// Depends on aalr_pkg.
module aalr_datapath #(
   parameter int COORD_BITS = aalr_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = aalr_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  aalr_pkg::req_type                   req_data,
   input  logic                                csr_wen,
   input  logic [aalr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [aalr_pkg::CSR_W-1:0]          csr_wdata,
   input  aalr_pkg::cmd_type                   cmd,
   output aalr_pkg::status_type                status,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output aalr_pkg::rsp_type                   rsp_data
);

   localparam int NW    = COORD_BITS + FRAC_BITS;   // dividend, quotient and accumulator
   localparam int CNT_W = $clog2(NW);

   // Configuration
   logic [aalr_pkg::CSR_W-1:0] width_ff, height_ff;

   // Line state
   logic                   steep_ff, neg_ff, zero_ff;
   logic [COORD_BITS-1:0]  start_ff, stop_ff, minor0_ff, minor1_ff, dx_ff, pos_ff;
   logic [aalr_pkg::COLOR_W-1:0] color_ff;
   logic [NW-1:0]          acc_ff;

   // Divider: the remainder stays below dx
   logic [COORD_BITS-1:0]  rem_ff;
   logic [NW-1:0]          quo_ff;
   logic [CNT_W-1:0]       cnt_ff;

   // Output register
   logic                   rsp_valid_ff;
   aalr_pkg::rsp_type      rsp_ff, rsp_in;

   // Endpoint ordering at load
   logic [COORD_BITS-1:0]  ax0, ay0, ax1, ay1, adx, ady;
   logic [COORD_BITS-1:0]  sx0, sy0, sx1, sy1, ox0, oy0, ox1, oy1, dmin;
   logic                   steep_w, zero_w;

   always_comb begin
      ax0     = req_data.x_start[COORD_BITS-1:0];
      ay0     = req_data.y_start[COORD_BITS-1:0];
      ax1     = req_data.x_finish[COORD_BITS-1:0];
      ay1     = req_data.y_finish[COORD_BITS-1:0];
      adx     = (ax1 > ax0) ? ax1 - ax0 : ax0 - ax1;
      ady     = (ay1 > ay0) ? ay1 - ay0 : ay0 - ay1;
      zero_w  = (ax0 == ax1) && (ay0 == ay1);
      steep_w = ady > adx;
      sx0     = steep_w ? ay0 : ax0;
      sy0     = steep_w ? ax0 : ay0;
      sx1     = steep_w ? ay1 : ax1;
      sy1     = steep_w ? ax1 : ay1;
      if (sx0 > sx1) begin
         ox0 = sx1; oy0 = sy1; ox1 = sx0; oy1 = sy0;
      end else begin
         ox0 = sx0; oy0 = sy0; ox1 = sx1; oy1 = sy1;
      end
      dmin = (oy1 < oy0) ? oy0 - oy1 : oy1 - oy0;
   end

   // Restoring division step: one quotient bit per cycle
   logic [COORD_BITS:0] rem_sh;
   logic                q_bit;
   logic [NW-1:0]       slope_w;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[NW-1]};
      q_bit   = rem_sh >= {1'b0, dx_ff};
      slope_w = neg_ff ? (NW'(0) - quo_ff) : quo_ff;
   end

   // Control registers: configuration, divider count, output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= aalr_pkg::BITMAP_RESET;
         height_ff    <= aalr_pkg::BITMAP_RESET;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wen) begin
            unique case (csr_index)
               aalr_pkg::CSR_BITMAP_WIDTH:  width_ff  <= csr_wdata;
               aalr_pkg::CSR_BITMAP_HEIGHT: height_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.load) begin
            cnt_ff <= '0;
         end else if (cmd.div_step) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Line, divider and accumulator registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         steep_ff  <= steep_w;
         zero_ff   <= zero_w;
         start_ff  <= ox0;
         stop_ff   <= ox1;
         minor0_ff <= oy0;
         minor1_ff <= oy1;
         neg_ff    <= oy1 < oy0;
         dx_ff     <= ox1 - ox0;
         color_ff  <= req_data.line_color;
         rem_ff    <= '0;
         quo_ff    <= NW'(dmin) << FRAC_BITS;
      end else if (cmd.div_step) begin
         rem_ff <= COORD_BITS'(q_bit ? rem_sh - {1'b0, dx_ff} : rem_sh);
         quo_ff <= {quo_ff[NW-2:0], q_bit};
      end
      if (cmd.start_body) begin
         acc_ff <= (NW'(minor0_ff) << FRAC_BITS) + slope_w;
         pos_ff <= start_ff + COORD_BITS'(1);
      end else if (cmd.body_step) begin
         acc_ff <= acc_ff + slope_w;
         pos_ff <= pos_ff + COORD_BITS'(1);
      end
      if (cmd.out_load) begin
         rsp_ff <= rsp_in;
      end
   end

   // Result build
   logic [COORD_BITS-1:0]         maj, mnr;
   logic [COORD_BITS:0]           mnr_far;
   logic [7:0]                    frac8;
   logic [aalr_pkg::WEIGHT_W-1:0] w_near, w_far;
   logic                          last_w, body_last_w, unit_dx_w;
   logic [aalr_pkg::PIX_W-1:0]    nx, ny, fx, fy;

   always_comb begin
      frac8       = acc_ff[FRAC_BITS-1 -: 8];
      unit_dx_w   = dx_ff == COORD_BITS'(1);
      body_last_w = ({1'b0, pos_ff} + (COORD_BITS+1)'(1)) == {1'b0, stop_ff};
      case (cmd.out_sel)
         aalr_pkg::SEL_ZERO: begin
            maj = start_ff; mnr = minor0_ff;
            w_near = aalr_pkg::WEIGHT_FULL; w_far = aalr_pkg::WEIGHT_NONE;
            last_w = 1'b1;
         end
         aalr_pkg::SEL_FIRST: begin
            maj = start_ff; mnr = minor0_ff;
            w_near = aalr_pkg::WEIGHT_HALF; w_far = aalr_pkg::WEIGHT_NONE;
            last_w = unit_dx_w;
         end
         aalr_pkg::SEL_SECOND: begin
            maj = stop_ff; mnr = minor1_ff;
            w_near = aalr_pkg::WEIGHT_HALF; w_far = aalr_pkg::WEIGHT_NONE;
            last_w = unit_dx_w;
         end
         default: begin
            maj = pos_ff; mnr = acc_ff[FRAC_BITS +: COORD_BITS];
            w_near = aalr_pkg::WEIGHT_FULL - {1'b0, frac8};
            w_far  = {1'b0, frac8};
            last_w = body_last_w;
         end
      endcase
      mnr_far = {1'b0, mnr} + (COORD_BITS+1)'(1);
      // Steep lines swap back to row-major positions
      if (steep_ff && !zero_ff) begin
         nx = aalr_pkg::PIX_W'(mnr);     ny = aalr_pkg::PIX_W'(maj);
         fx = aalr_pkg::PIX_W'(mnr_far); fy = aalr_pkg::PIX_W'(maj);
      end else begin
         nx = aalr_pkg::PIX_W'(maj);     ny = aalr_pkg::PIX_W'(mnr);
         fx = aalr_pkg::PIX_W'(maj);     fy = aalr_pkg::PIX_W'(mnr_far);
      end
      rsp_in.near_x      = nx;
      rsp_in.near_y      = ny;
      rsp_in.near_weight = w_near;
      rsp_in.near_inside = (nx < width_ff) && (ny < height_ff);
      rsp_in.pixel_color = color_ff;
      rsp_in.last_column = last_w;
      // Zero-length line carries no far pixel
      if (cmd.out_sel == aalr_pkg::SEL_ZERO) begin
         rsp_in.far_x      = '0;
         rsp_in.far_y      = '0;
         rsp_in.far_weight = aalr_pkg::WEIGHT_NONE;
         rsp_in.far_inside = 1'b0;
      end else begin
         rsp_in.far_x      = fx;
         rsp_in.far_y      = fy;
         rsp_in.far_weight = w_far;
         rsp_in.far_inside = (fx < width_ff) && (fy < height_ff);
      end
   end

   // Status back to the controller
   always_comb begin
      status.zero_len  = zero_w;
      status.div_last  = cnt_ff == CNT_W'(NW - 1);
      status.unit_dx   = unit_dx_w;
      status.body_last = body_last_w;
      status.out_free  = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[rtl/antialiased_line_rasterizer_top.sv]
// Top level of the anti-aliased line rasteriser: joins controller and datapath.
// Depends on aalr_pkg, aalr_ctrl and aalr_datapath.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | req_data  (aalr_pkg::req_type)
//   rsp     | out       | rsp_valid/rsp_stall | rsp_data  (aalr_pkg::rsp_type)
//   csr     | in        | csr_wen             | csr_index, csr_wdata
//
// A line is loaded, then the restoring slope divider forms the COORD_BITS+FRAC_BITS
// bit quotient (one quotient bit a cycle), then dx+1 results follow, one column a
// cycle on the accumulator unless stalled; a zero-length line gives one result. A new
// line is taken only once the last result is in the output register. Reset is
// synchronous and sets both bitmap registers to 64. A stalled result holds the sequence in place.
module antialiased_line_rasterizer_top #(
   parameter int COORD_BITS = aalr_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = aalr_pkg::FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  aalr_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output aalr_pkg::rsp_type                rsp_data,
   input  logic                             csr_wen,
   input  logic [aalr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [aalr_pkg::CSR_W-1:0]       csr_wdata
);

   aalr_pkg::cmd_type    cmd;
   aalr_pkg::status_type status;

   aalr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   aalr_datapath #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for antialiased_line_rasterizer_top: directed lines from a table,
// then random lines across several bitmap sizes, with random request gaps and result stalls.
// Depends on aalr_pkg and the rasteriser RTL.
module tb_top;

   localparam int FRAC            = aalr_pkg::FRAC_BITS_DEF;
   localparam int RESET_CYCLES    = 9;
   localparam int SETTLE_CYCLES   = 100;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int PHASES          = 10;
   localparam int LINES_PER_PHASE = 25;
   localparam int CYCLE_LIMIT     = 5_000_000;

   typedef struct {
      aalr_pkg::req_type line;
      bit                typed;
      aalr_pkg::rsp_type column;
   } sample_row_type;

   logic                             clock;
   logic                             reset;
   logic                             req_valid;
   logic                             req_stall;
   aalr_pkg::req_type                req_data;
   logic                             rsp_valid;
   logic                             rsp_stall;
   aalr_pkg::rsp_type                rsp_data;
   logic                             csr_wen;
   logic [aalr_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [aalr_pkg::CSR_W-1:0]       csr_wdata;

   // Predictor's copy of the bitmap size
   int bmp_width;
   int bmp_height;

   aalr_pkg::rsp_type pending_columns [$];
   sample_row_type    directed_rows [$];
   int                column_errors = 0;
   int                cycle_count = 0;
   bit                no_idle = 1'b0;
   bit                hold_off_due = 1'b0;

   antialiased_line_rasterizer_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("** antialiased_line_rasterizer_top: FAILED **");
         $finish;
      end
   end

   // Idle length: mostly short, now and then long, none in quiet phases
   function automatic int pick_gap();
      int roll;
      if (no_idle) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      else if (roll < 88) return $urandom_range(1, 3);
      else if (roll < 97) return $urandom_range(4, 12);
      else return $urandom_range(20, 60);
   endfunction

   function automatic bit pixel_inside(int x, int y);
      return (x < bmp_width) && (y < bmp_height);
   endfunction

   // One column: near pixel on the minor floor, far pixel one step on
   function automatic void push_column(bit steep, int major, int minor, int w_near, int w_far,
                                       bit last, logic [aalr_pkg::COLOR_W-1:0] color);
      aalr_pkg::rsp_type col;
      int                nx, ny, fx, fy;
      if (steep) begin
         nx = minor; ny = major; fx = minor + 1; fy = major;
      end else begin
         nx = major; ny = minor; fx = major; fy = minor + 1;
      end
      col.near_x      = aalr_pkg::PIX_W'(nx);
      col.near_y      = aalr_pkg::PIX_W'(ny);
      col.near_weight = aalr_pkg::WEIGHT_W'(w_near);
      col.near_inside = pixel_inside(nx, ny);
      col.far_x       = aalr_pkg::PIX_W'(fx);
      col.far_y       = aalr_pkg::PIX_W'(fy);
      col.far_weight  = aalr_pkg::WEIGHT_W'(w_far);
      col.far_inside  = pixel_inside(fx, fy);
      col.pixel_color = color;
      col.last_column = last;
      pending_columns.push_back(col);
   endfunction

   // Expected columns of one line: endpoints at half weight, then the interior; one pixel if zero-length
   function automatic void rasterise_line(aalr_pkg::req_type line);
      aalr_pkg::rsp_type col;
      int                x0, y0, x1, y1, adx, ady, tmp, dx, major, minor, frac8;
      bit                steep;
      longint            slope_q, acc;
      x0 = line.x_start;
      y0 = line.y_start;
      x1 = line.x_finish;
      y1 = line.y_finish;
      // Zero-length line: a single full-weight pixel, far fields cleared
      if (x0 == x1 && y0 == y1) begin
         col             = '0;
         col.near_x      = aalr_pkg::PIX_W'(x0);
         col.near_y      = aalr_pkg::PIX_W'(y0);
         col.near_weight = aalr_pkg::WEIGHT_FULL;
         col.near_inside = pixel_inside(x0, y0);
         col.pixel_color = line.line_color;
         col.last_column = 1'b1;
         pending_columns.push_back(col);
         return;
      end
      adx   = (x1 > x0) ? x1 - x0 : x0 - x1;
      ady   = (y1 > y0) ? y1 - y0 : y0 - y1;
      steep = ady > adx;
      if (steep) begin
         tmp = x0; x0 = y0; y0 = tmp;
         tmp = x1; x1 = y1; y1 = tmp;
      end
      if (x0 > x1) begin
         tmp = x0; x0 = x1; x1 = tmp;
         tmp = y0; y0 = y1; y1 = tmp;
      end
      dx = x1 - x0;
      // signed division truncates toward zero
      slope_q = (longint'(y1 - y0) * (longint'(1) << FRAC)) / dx;
      push_column(steep, x0, y0, aalr_pkg::WEIGHT_HALF, aalr_pkg::WEIGHT_NONE, dx == 1,
                  line.line_color);
      push_column(steep, x1, y1, aalr_pkg::WEIGHT_HALF, aalr_pkg::WEIGHT_NONE, dx == 1,
                  line.line_color);
      acc = (longint'(y0) << FRAC) + slope_q;
      for (major = x0 + 1; major < x1; major++) begin
         minor = int'(acc >>> FRAC);
         frac8 = int'((acc & ((longint'(1) << FRAC) - 1)) >> (FRAC - 8));
         push_column(steep, major, minor, 256 - frac8, frac8, major + 1 == x1, line.line_color);
         acc += slope_q;
      end
   endfunction

   function automatic void add_row(int x0, int y0, int x1, int y1, int color,
                                   bit typed = 1'b0, aalr_pkg::rsp_type column = '0);
      sample_row_type row;
      row.line.x_start    = aalr_pkg::IN_COORD_W'(x0);
      row.line.y_start    = aalr_pkg::IN_COORD_W'(y0);
      row.line.x_finish   = aalr_pkg::IN_COORD_W'(x1);
      row.line.y_finish   = aalr_pkg::IN_COORD_W'(y1);
      row.line.line_color = aalr_pkg::COLOR_W'(color);
      row.typed           = typed;
      row.column          = column;
      directed_rows.push_back(row);
   endfunction

   function automatic int rim_coord();
      return $urandom_range(0, 1) ? $urandom_range(0, 1) : 62 + $urandom_range(0, 1);
   endfunction

   function automatic int near_coord(int c);
      int n;
      n = c + $urandom_range(0, 8) - 4;
      return (n < 0) ? 0 : (n > 63) ? 63 : n;
   endfunction

   // Random line: over half are awkward shapes, the rest arbitrary
   function automatic aalr_pkg::req_type random_line();
      aalr_pkg::req_type line;
      int                kind, x0, y0, x1, y1, span, tmp;
      kind = $urandom_range(0, 99);
      x0 = $urandom_range(0, 63);
      y0 = $urandom_range(0, 63);
      x1 = $urandom_range(0, 63);
      y1 = $urandom_range(0, 63);
      if (kind < 8) begin
         x1 = x0; y1 = y0;
      end else if (kind < 14) begin
         y1 = y0;
      end else if (kind < 20) begin
         x1 = x0;
      end else if (kind < 27) begin
         span = $urandom_range(1, 63);
         x0 = $urandom_range(0, 63 - span);
         y0 = $urandom_range(0, 63 - span);
         x1 = x0 + span;
         y1 = y0 + span;
         if ($urandom_range(0, 1)) begin
            tmp = y0; y0 = y1; y1 = tmp;
         end
      end else if (kind < 37) begin
         x0 = rim_coord(); y0 = rim_coord(); x1 = rim_coord(); y1 = rim_coord();
      end else if (kind < 55) begin
         x1 = near_coord(x0); y1 = near_coord(y0);
      end
      line.x_start    = aalr_pkg::IN_COORD_W'(x0);
      line.y_start    = aalr_pkg::IN_COORD_W'(y0);
      line.x_finish   = aalr_pkg::IN_COORD_W'(x1);
      line.y_finish   = aalr_pkg::IN_COORD_W'(y1);
      line.line_color = aalr_pkg::COLOR_W'($urandom);
      return line;
   endfunction

   // Offer one line and wait for its transfer; called at a rising edge
   task automatic offer_line(input aalr_pkg::req_type line, input bit typed,
                             input aalr_pkg::rsp_type column);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= line;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (typed) pending_columns.push_back(column);
      else rasterise_line(line);
   endtask

   task automatic drain_columns();
      while (pending_columns.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_bitmap_size(input logic [aalr_pkg::CSR_W-1:0] w,
                                    input logic [aalr_pkg::CSR_W-1:0] h);
      csr_wen   <= 1'b1;
      csr_index <= aalr_pkg::CSR_BITMAP_WIDTH;
      csr_wdata <= w;
      @(posedge clock);
      csr_index <= aalr_pkg::CSR_BITMAP_HEIGHT;
      csr_wdata <= h;
      @(posedge clock);
      csr_wen    <= 1'b0;
      bmp_width  = w;
      bmp_height = h;
   endtask

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d got %0d", $time, name, want, got);
         column_errors++;
      end
   endtask

   // Result channel: every transfer against the oldest expected column
   always @(posedge clock) begin : column_check
      aalr_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_columns.size() == 0) begin
            $display("%0t: unexpected column, expected none got %h", $time, rsp_data);
            column_errors++;
         end else begin
            want = pending_columns.pop_front();
            check_field("near_x", want.near_x, rsp_data.near_x);
            check_field("near_y", want.near_y, rsp_data.near_y);
            check_field("near_weight", want.near_weight, rsp_data.near_weight);
            check_field("near_inside", want.near_inside, rsp_data.near_inside);
            check_field("far_x", want.far_x, rsp_data.far_x);
            check_field("far_y", want.far_y, rsp_data.far_y);
            check_field("far_weight", want.far_weight, rsp_data.far_weight);
            check_field("far_inside", want.far_inside, rsp_data.far_inside);
            check_field("pixel_color", want.pixel_color, rsp_data.pixel_color);
            check_field("last_column", want.last_column, rsp_data.last_column);
         end
      end
   end

   // Receiver stalls; a requested hold-off is counted here
   initial begin : receiver_stall
      int n;
      rsp_stall = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_due) begin
            hold_off_due = 1'b0;
            n = HOLD_OFF_CYCLES;
         end else begin
            n = pick_gap();
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
      end
   end

   initial begin : stimulus
      aalr_pkg::rsp_type corner;
      int                phase, w, h;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      csr_wen    = 1'b0;
      csr_index  = aalr_pkg::CSR_BITMAP_WIDTH;
      csr_wdata  = '0;
      bmp_width  = aalr_pkg::BITMAP_RESET;
      bmp_height = aalr_pkg::BITMAP_RESET;

      // Zero-length lines at two corners and at (42,21), known at a glance under the reset size
      corner = '{near_x: 7'd0, near_y: 7'd0, near_weight: aalr_pkg::WEIGHT_FULL,
                 near_inside: 1'b1, far_x: 7'd0, far_y: 7'd0,
                 far_weight: aalr_pkg::WEIGHT_NONE, far_inside: 1'b0,
                 pixel_color: 24'h000000, last_column: 1'b1};
      add_row(0, 0, 0, 0, 'h000000, 1'b1, corner);
      corner = '{near_x: 7'd63, near_y: 7'd63, near_weight: aalr_pkg::WEIGHT_FULL,
                 near_inside: 1'b1, far_x: 7'd0, far_y: 7'd0,
                 far_weight: aalr_pkg::WEIGHT_NONE, far_inside: 1'b0,
                 pixel_color: 24'hFFFFFF, last_column: 1'b1};
      add_row(63, 63, 63, 63, 'hFFFFFF, 1'b1, corner);
      corner = '{near_x: 7'd42, near_y: 7'd21, near_weight: aalr_pkg::WEIGHT_FULL,
                 near_inside: 1'b1, far_x: 7'd0, far_y: 7'd0,
                 far_weight: aalr_pkg::WEIGHT_NONE, far_inside: 1'b0,
                 pixel_color: 24'hAAAAAA, last_column: 1'b1};
      add_row(42, 21, 42, 21, 'hAAAAAA, 1'b1, corner);
      // Full-span horizontal, vertical and both diagonals
      add_row(0, 0, 63, 0, 'h123456);
      add_row(5, 0, 5, 63, 'h654321);
      add_row(0, 0, 63, 63, 'hFF0000);
      add_row(0, 63, 63, 0, 'h00FF00);
      // Reversed endpoints, shallow and steep, both slope signs; then a falling diagonal
      add_row(63, 10, 0, 40, 'h0000FF);
      add_row(40, 63, 10, 0, 'h555555);
      add_row(21, 42, 42, 21, 'hAAAAAA);
      // Shortest lines: one and two major steps
      add_row(10, 10, 11, 10, 'h010203);
      add_row(12, 9, 12, 10, 'h0F0F0F);
      add_row(20, 5, 22, 6, 'hF0F0F0);
      // Far pixel one past the last row or column
      add_row(0, 63, 10, 63, 'h808080);
      add_row(63, 0, 63, 20, 'h7F7F7F);
      // Fine fractions
      add_row(0, 0, 63, 1, 'hC0FFEE);
      add_row(0, 1, 63, 0, 'h3C3C3C);
      add_row(3, 7, 50, 30, 'h999999);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         offer_line(directed_rows[i].line, directed_rows[i].typed, directed_rows[i].column);

      // Random lines, one bitmap size per phase
      for (phase = 0; phase < PHASES; phase++) begin
         req_valid <= 1'b0;
         drain_columns();
         case (phase)
            0: begin w = 64; h = 64; end
            1: begin w = 1; h = 1; end
            2: begin w = 64; h = 64; end
            3: begin w = 0; h = 64; end
            4: begin w = 64; h = 0; end
            5: begin w = 127; h = 127; end
            6: begin w = 63; h = 1; end
            7: begin w = 1; h = 63; end
            default: begin w = $urandom_range(1, 64); h = $urandom_range(1, 64); end
         endcase
         write_bitmap_size(aalr_pkg::CSR_W'(w), aalr_pkg::CSR_W'(h));
         no_idle = (phase % 4 == 3);
         // Long receiver hold-off while lines keep coming, to fill the block
         if (phase == 2) begin
            no_idle      = 1'b1;
            hold_off_due = 1'b1;
         end
         repeat (LINES_PER_PHASE) offer_line(random_line(), 1'b0, '0);
      end

      req_valid <= 1'b0;
      no_idle = 1'b0;
      drain_columns();
      if (column_errors == 0) begin
         $display("** antialiased_line_rasterizer_top: PASSED **");
      end else begin
         $display("** antialiased_line_rasterizer_top: FAILED **");
      end
      $finish;
   end

endmodule
